/* hw/rtl/tkhv_pkg.sv */
// shared types and constants for the tick/hash line validator
// word formats, status codes, character codes and result queue sizing
// no dependencies
package tkhv_pkg;

	localparam int MAX_LINE_BYTES = 64;
	localparam int LINE_LIMIT_CAP = 65536;
	localparam int HEX_DIGITS     = 16;
	localparam int TICK_MAX       = 65535;
	localparam int TICK_SAT       = 65536;

	localparam int LB_W     = 7;
	localparam int CNT_W    = 17;
	localparam int TICK_W   = 16;
	localparam int HASH_W   = 64;
	localparam int HEXCNT_W = 5;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_LVL_W = FIFO_PTR_W + 1;

	localparam logic KIND_LINE    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_F     = 8'h66;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_SEQ_BREAK = 3'd2,
		ST_UNBOUNDED = 3'd3,
		ST_NO_LINES  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] byte_req;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic              kind;
		status_t           status;
		logic [CNT_W-1:0]  line_number;
		logic [TICK_W-1:0] tick;
		logic [HASH_W-1:0] hash;
		logic              last;
	} out_word_t;

	// up to two results per input word, res0 first
	typedef struct packed {
		logic      valid0;
		logic      valid1;
		out_word_t res0;
		out_word_t res1;
	} res_push_t;

endpackage

/* hw/rtl/tick_hash_line_validator.sv */
// tick/hash line validator: checks "<tick> <16 hex digits>" lines of a byte stream
// input register, line parser and a four-entry result queue
// depends on tkhv_pkg, tkhv_parser, tkhv_result_fifo
//
// Input channel: one word per byte (byte_req) or an end-of-stream mark.
// Output channel: one word per completed line, plus a verdict word at end
// of stream; the last word caused by an input word has last set.
// Configuration: cfg_wr_en/cfg_wr_data write max_lines; the user must do this
// only while the block is idle; the block does not enforce it. Throughput: one
// input word per cycle while in_stall is low. A word is registered on acceptance
// and parsed once the result queue has room. An end-of-stream word with a pending
// line yields two results; they leave the queue one per cycle unless stalled.
// The parser moves only while the result queue has room for two words;
// when the receiver stalls, the queue fills and in_stall rises after the
// held word, so nothing is lost.
// Reset clears all stream state and the queue; max_lines returns to 65536.
module tick_hash_line_validator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tkhv_pkg::in_word_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tkhv_pkg::out_word_t        out_data,
	input  logic                       cfg_wr_en,
	input  logic [tkhv_pkg::CNT_W-1:0] cfg_wr_data
);
	import tkhv_pkg::*;

	logic                  valid_s1;
	in_word_t              word_s1;
	logic [CNT_W-1:0]      max_lines_q;
	logic                  advance;
	logic                  take;
	res_push_t             push;
	logic [FIFO_LVL_W-1:0] level;
	logic                  pop;

	assign advance  = level <= FIFO_LVL_W'(FIFO_DEPTH - 2);
	assign take     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign out_valid = level != '0;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lines_q <= CNT_W'(LINE_LIMIT_CAP);
		end else if (cfg_wr_en) begin
			max_lines_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_data;
		end
	end

	tkhv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_lines (max_lines_q),
		.take      (take),
		.word      (word_s1),
		.push      (push)
	);

	tkhv_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (out_data),
		.level  (level)
	);

	// queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= FIFO_LVL_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	// a verdict always closes its input word and carries no tick or hash
	a_verdict_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.kind == KIND_VERDICT)) |->
			(out_data.last && (out_data.tick == '0) && (out_data.hash == '0)))
		else $error("malformed verdict word");

	// a parsed word never pushes into a queue without room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid0 || push.valid1) |-> (take && (level <= FIFO_LVL_W'(FIFO_DEPTH - 2))))
		else $error("push without room");

endmodule

/* hw/rtl/tkhv_parser.sv */
// per-byte line parser and stream bookkeeping
// holds line and stream state, emits line results and the end-of-stream verdict
// depends on tkhv_pkg
module tkhv_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tkhv_pkg::CNT_W-1:0] max_lines,
	input  logic                       take,
	input  tkhv_pkg::in_word_t         word,
	output tkhv_pkg::res_push_t        push
);
	import tkhv_pkg::*;

	typedef struct packed {
		logic [LB_W-1:0]     line_bytes;
		logic                in_hash_part;
		logic [CNT_W-1:0]    tick_accum;
		logic [1:0]          digit_count;
		logic                first_digit_zero;
		logic [HEXCNT_W-1:0] hex_count;
		logic [HASH_W-1:0]   hash_accum;
		logic                line_malformed;
		logic                cr_held;
	} line_state_t;

	line_state_t       line_q, line_n;
	logic [CNT_W-1:0]  line_count_q, line_count_n;
	logic              overflowed_q, overflowed_n;
	status_t           first_error_code_q, first_error_code_n;
	logic [TICK_W-1:0] first_error_line_q, first_error_line_n;

	logic [CNT_W-1:0]  lim;
	logic              fin_full;
	logic              fin_bad;
	status_t           fin_status;
	logic              fe_take;
	out_word_t         line_res;
	out_word_t         verdict;
	logic              do_fin;

	logic [7:0]        c;
	logic              is_dec;
	logic              is_hex;
	logic [3:0]        digit;
	logic [CNT_W+3:0]  tick_x10;

	assign c      = word.byte_req;
	assign is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_hex = (c >= CH_A) && (c <= CH_F);
	assign digit  = is_dec ? c[3:0] : (c[3:0] + 4'd9);
	assign tick_x10 = (CNT_W+4)'({line_q.tick_accum, 3'b000})
		+ (CNT_W+4)'({line_q.tick_accum, 1'b0}) + (CNT_W+4)'(c[3:0]);

	always_comb begin
		if (max_lines == '0) begin
			lim = CNT_W'(1);
		end else if (max_lines > CNT_W'(LINE_LIMIT_CAP)) begin
			lim = CNT_W'(LINE_LIMIT_CAP);
		end else begin
			lim = max_lines;
		end
	end

	// line completion: result for the pending line
	assign fin_full = line_count_q >= lim;
	assign fin_bad  = line_q.line_malformed || !line_q.in_hash_part
		|| (line_q.hex_count != HEXCNT_W'(HEX_DIGITS))
		|| (line_q.first_digit_zero && (line_q.digit_count >= 2'd2));
	assign fin_status = fin_bad ? ST_MALFORMED
		: ((line_q.tick_accum == line_count_q) ? ST_OK : ST_SEQ_BREAK);
	assign fe_take = (fin_status != ST_OK) && (first_error_code_q == ST_OK);

	always_comb begin
		line_res             = '0;
		line_res.kind        = KIND_LINE;
		line_res.status      = fin_status;
		line_res.line_number = line_count_q;
		if (!fin_bad) begin
			line_res.tick = (line_q.tick_accum > CNT_W'(TICK_MAX)) ? TICK_W'(TICK_MAX)
				: line_q.tick_accum[TICK_W-1:0];
			line_res.hash = line_q.hash_accum;
		end
	end

	always_comb begin
		line_n             = line_q;
		line_count_n       = line_count_q;
		overflowed_n       = overflowed_q;
		first_error_code_n = first_error_code_q;
		first_error_line_n = first_error_line_q;
		push               = '0;
		verdict            = '0;
		do_fin             = 1'b0;
		if (take) begin
			if (word.end_of_stream) begin
				do_fin = !overflowed_q && (line_q.line_bytes != '0);
				if (do_fin) begin
					if (fin_full) begin
						overflowed_n = 1'b1;
					end else begin
						push.valid0  = 1'b1;
						push.res0    = line_res;
						line_count_n = line_count_q + CNT_W'(1);
						if (fe_take) begin
							first_error_code_n = fin_status;
							first_error_line_n = line_count_q[TICK_W-1:0];
						end
					end
				end
				verdict.kind = KIND_VERDICT;
				verdict.last = 1'b1;
				if (overflowed_n) begin
					verdict.status      = ST_UNBOUNDED;
					verdict.line_number = line_count_n;
				end else if (line_count_n == '0) begin
					verdict.status = ST_NO_LINES;
				end else if (first_error_code_n != ST_OK) begin
					verdict.status      = first_error_code_n;
					verdict.line_number = CNT_W'(first_error_line_n);
				end else begin
					verdict.status      = ST_OK;
					verdict.line_number = line_count_n;
				end
				if (push.valid0) begin
					push.valid1 = 1'b1;
					push.res1   = verdict;
				end else begin
					push.valid0 = 1'b1;
					push.res0   = verdict;
				end
				// fresh stream after the verdict
				line_n             = '0;
				line_count_n       = '0;
				overflowed_n       = 1'b0;
				first_error_code_n = ST_OK;
				first_error_line_n = '0;
			end else if (!overflowed_q) begin
				if (c == CH_LF) begin
					if (fin_full) begin
						overflowed_n = 1'b1;
					end else begin
						push.valid0      = 1'b1;
						push.res0        = line_res;
						push.res0.last   = 1'b1;
						line_count_n     = line_count_q + CNT_W'(1);
						if (fe_take) begin
							first_error_code_n = fin_status;
							first_error_line_n = line_count_q[TICK_W-1:0];
						end
					end
					line_n = '0;
				end else if (line_q.line_bytes >= LB_W'(MAX_LINE_BYTES)) begin
					overflowed_n = 1'b1;
					line_n       = '0;
				end else begin
					line_n.line_bytes = line_q.line_bytes + LB_W'(1);
					// a held cr followed by more text is a stray cr
					if (line_q.cr_held) begin
						line_n.line_malformed = 1'b1;
					end
					line_n.cr_held = (c == CH_CR);
					if (c != CH_CR) begin
						if (!line_q.in_hash_part) begin
							if (c == CH_SPACE) begin
								if (line_q.digit_count == 2'd0) begin
									line_n.line_malformed = 1'b1;
								end
								line_n.in_hash_part = 1'b1;
							end else if (is_dec) begin
								if ((line_q.digit_count == 2'd0) && (c == CH_ZERO)) begin
									line_n.first_digit_zero = 1'b1;
								end
								if (line_q.digit_count < 2'd2) begin
									line_n.digit_count = line_q.digit_count + 2'd1;
								end
								line_n.tick_accum = (tick_x10 > (CNT_W+4)'(TICK_MAX))
									? CNT_W'(TICK_SAT) : tick_x10[CNT_W-1:0];
							end else begin
								line_n.line_malformed = 1'b1;
							end
						end else if (is_dec || is_hex) begin
							if (line_q.hex_count < HEXCNT_W'(HEX_DIGITS)) begin
								line_n.hash_accum = {line_q.hash_accum[HASH_W-5:0], digit};
							end
							if (line_q.hex_count <= HEXCNT_W'(HEX_DIGITS)) begin
								line_n.hex_count = line_q.hex_count + HEXCNT_W'(1);
							end
						end else begin
							line_n.line_malformed = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q             <= '0;
			line_count_q       <= '0;
			overflowed_q       <= 1'b0;
			first_error_code_q <= ST_OK;
			first_error_line_q <= '0;
		end else begin
			line_q             <= line_n;
			line_count_q       <= line_count_n;
			overflowed_q       <= overflowed_n;
			first_error_code_q <= first_error_code_n;
			first_error_line_q <= first_error_line_n;
		end
	end

endmodule

/* hw/rtl/tkhv_result_fifo.sv */
// small result queue: takes up to two words a cycle, gives one
// the head entry drives the output channel directly
// depends on tkhv_pkg
module tkhv_result_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tkhv_pkg::res_push_t             push,
	input  logic                            pop,
	output tkhv_pkg::out_word_t             head,
	output logic [tkhv_pkg::FIFO_LVL_W-1:0] level
);
	import tkhv_pkg::*;

	out_word_t             mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_LVL_W-1:0] level_q;
	logic [FIFO_PTR_W-1:0] wr_ptr1;
	logic [FIFO_LVL_W-1:0] n_push;

	assign wr_ptr1 = wr_ptr_q + FIFO_PTR_W'(push.valid0);
	assign n_push  = FIFO_LVL_W'(push.valid0) + FIFO_LVL_W'(push.valid1);
	assign head    = mem[rd_ptr_q];
	assign level   = level_q;

	always_ff @(posedge clk) begin
		if (push.valid0) begin
			mem[wr_ptr_q] <= push.res0;
		end
		if (push.valid1) begin
			mem[wr_ptr1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			level_q  <= level_q + n_push - FIFO_LVL_W'(pop);
		end
	end

endmodule

/* verif/tb_tick_hash_line_validator.sv */
// testbench for tick_hash_line_validator: byte streams in, line results and verdicts checked
// against an in-bench line parser model under several max_lines settings
// depends on tkhv_pkg and the tick_hash_line_validator rtl
module tb_tick_hash_line_validator;
	timeunit 1ns;
	timeprecision 1ps;

	import tkhv_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 8;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	in_word_t          in_data     = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	out_word_t         out_data;
	logic              cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0]  cfg_wr_data = '0;

	tick_hash_line_validator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	in_word_t  bytes_to_send[$];
	out_word_t pending_results[$];

	int mismatches     = 0;
	int words_queued   = 0;
	int words_sent     = 0;
	int line_results   = 0;
	int verdicts[5]    = '{default: 0};
	int limit_settings = 0;
	int cycle_cnt      = 0;
	int burst_left     = 16;
	int gap_left       = 0;
	int stall_mode     = 0;
	int stall_left     = 0;
	int stall_run      = 0;

	// line parser model state
	logic [CNT_W-1:0]  limit_reg = CNT_W'(LINE_LIMIT_CAP);
	int unsigned       ln_bytes, tick_acc, tick_digits, hex_seen, line_cnt;
	bit                in_hex, lead_zero, line_bad, cr_pending, unbounded;
	logic [HASH_W-1:0] hash_acc;
	status_t           err_status;
	logic [15:0]       err_line;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_line_st();
		ln_bytes = 0;
		in_hex = 0;
		tick_acc = 0;
		tick_digits = 0;
		lead_zero = 0;
		hex_seen = 0;
		hash_acc = '0;
		line_bad = 0;
		cr_pending = 0;
	endfunction

	function automatic void clear_stream_st();
		clear_line_st();
		line_cnt = 0;
		unbounded = 0;
		err_status = ST_OK;
		err_line = '0;
	endfunction

	function automatic int unsigned line_cap(input logic [CNT_W-1:0] v);
		int unsigned lim;
		lim = (v == 0) ? 1 : v;
		if (lim > LINE_LIMIT_CAP) lim = LINE_LIMIT_CAP;
		return lim;
	endfunction

	// completes the current line; returns 0 when the line limit drops it
	function automatic bit close_line(output out_word_t r);
		bit bad;
		r = '0;
		if (line_cnt >= line_cap(limit_reg)) begin
			unbounded = 1;
			clear_line_st();
			return 0;
		end
		bad = line_bad || !in_hex || hex_seen != HEX_DIGITS || (lead_zero && tick_digits >= 2);
		r.kind = KIND_LINE;
		r.line_number = CNT_W'(line_cnt);
		if (bad) begin
			r.status = ST_MALFORMED;
		end else begin
			r.tick = (tick_acc > TICK_MAX) ? TICK_W'(TICK_MAX) : TICK_W'(tick_acc);
			r.hash = hash_acc;
			r.status = (tick_acc == line_cnt) ? ST_OK : ST_SEQ_BREAK;
		end
		if (r.status != ST_OK && err_status == ST_OK) begin
			err_status = r.status;
			err_line = 16'(line_cnt);
		end
		line_cnt++;
		clear_line_st();
		return 1;
	endfunction

	function automatic void take_char(input logic [7:0] c);
		int unsigned cv, t, d;
		cv = c;
		if (!in_hex) begin
			if (c == CH_SPACE) begin
				if (tick_digits == 0) line_bad = 1;
				in_hex = 1;
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				if (tick_digits == 0 && c == CH_ZERO) lead_zero = 1;
				if (tick_digits < 2) tick_digits++;
				t = tick_acc * 10 + (cv - CH_ZERO);
				tick_acc = (t > TICK_MAX) ? TICK_SAT : t;
			end else begin
				line_bad = 1;
			end
		end else begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = cv - CH_ZERO;
			end else if (c >= CH_A && c <= CH_F) begin
				d = cv - CH_A + 10;
			end else begin
				line_bad = 1;
				return;
			end
			if (hex_seen < HEX_DIGITS) hash_acc = {hash_acc[HASH_W-5:0], 4'(d)};
			if (hex_seen <= HEX_DIGITS) hex_seen++;
		end
	endfunction

	// advances the model by one accepted word and queues the results it causes
	function automatic void parse_word(input in_word_t w);
		out_word_t r;
		out_word_t found[$];
		int n;
		if (w.end_of_stream) begin
			if (!unbounded && ln_bytes > 0) begin
				if (close_line(r)) found.insert(found.size(), r);
			end
			r = '0;
			r.kind = KIND_VERDICT;
			if (unbounded) begin
				r.status = ST_UNBOUNDED;
				r.line_number = CNT_W'(line_cnt);
			end else if (line_cnt == 0) begin
				r.status = ST_NO_LINES;
			end else if (err_status != ST_OK) begin
				r.status = err_status;
				r.line_number = CNT_W'(err_line);
			end else begin
				r.status = ST_OK;
				r.line_number = CNT_W'(line_cnt);
			end
			found.insert(found.size(), r);
			clear_stream_st();
		end else if (!unbounded) begin
			if (w.byte_req == CH_LF) begin
				if (close_line(r)) found.insert(found.size(), r);
			end else if (ln_bytes >= MAX_LINE_BYTES) begin
				unbounded = 1;
				clear_line_st();
			end else begin
				ln_bytes++;
				if (cr_pending) begin
					line_bad = 1;
					cr_pending = 0;
				end
				if (w.byte_req == CH_CR) cr_pending = 1;
				else take_char(w.byte_req);
			end
		end
		n = found.size();
		for (int i = 0; i < n; i++) begin
			r = found[i];
			r.last = (i == n - 1);
			pending_results.insert(pending_results.size(), r);
		end
	endfunction

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_word(in_data);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (bytes_to_send.size() > 0) begin
					in_data <= bytes_to_send.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
							: $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern: one of four modes, switched at random
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 30);
			2: begin
				if (stall_run > 0) begin
					stall_run--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 15) == 0) stall_run = $urandom_range(5, 30);
				end
			end
			default: out_stall <= !out_stall;
		endcase
	end

	task automatic check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h got %0h", name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : mon
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: %0h", out_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(out_data.kind));
				check_field("status", 64'(want.status), 64'(out_data.status));
				check_field("line_number", 64'(want.line_number), 64'(out_data.line_number));
				check_field("tick", 64'(want.tick), 64'(out_data.tick));
				check_field("hash", want.hash, out_data.hash);
				check_field("last", 64'(want.last), 64'(out_data.last));
				if (want.kind == KIND_VERDICT) verdicts[int'(want.status)]++;
				else line_results++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_tick_hash_line_validator: errors");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		in_word_t w;
		w.byte_req = b;
		w.end_of_stream = 1'b0;
		bytes_to_send.insert(bytes_to_send.size(), w);
		words_queued++;
	endtask

	task automatic push_eos();
		in_word_t w;
		w.byte_req = 8'($urandom_range(0, 255));
		w.end_of_stream = 1'b1;
		bytes_to_send.insert(bytes_to_send.size(), w);
		words_queued++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	function automatic logic [7:0] hex_char(input int d);
		return (d < 10) ? 8'(CH_ZERO + d) : 8'(CH_A + d - 10);
	endfunction

	task automatic gen_line(input int idx);
		int roll, tick_v, n_hex, n_sp, upper_at, cr_at, d;
		bit zero_lead, skip_tick, cr_end, cr_twice;
		logic [7:0] b;
		roll = $urandom_range(0, 99);
		tick_v = idx;
		n_hex = HEX_DIGITS;
		n_sp = 1;
		upper_at = -1;
		cr_at = -1;
		zero_lead = 0;
		skip_tick = 0;
		cr_twice = 0;
		cr_end = ($urandom_range(0, 3) == 0);
		if (roll < 45) begin
			// well-formed
		end else if (roll < 50) begin
			tick_v = idx + $urandom_range(1, 3);
		end else if (roll < 54) begin
			zero_lead = 1;
		end else if (roll < 58) begin
			tick_v = ($urandom_range(0, 1) == 0) ? TICK_MAX : $urandom_range(TICK_SAT, 999999);
		end else if (roll < 62) begin
			upper_at = $urandom_range(0, HEX_DIGITS - 1);
		end else if (roll < 66) begin
			n_hex = ($urandom_range(0, 1) == 0) ? HEX_DIGITS - 1 : HEX_DIGITS + 1;
		end else if (roll < 70) begin
			n_sp = 2 * $urandom_range(0, 1);
		end else if (roll < 74) begin
			cr_at = $urandom_range(0, HEX_DIGITS - 1);
		end else if (roll < 79) begin
			// arbitrary bytes, never a line end
			repeat ($urandom_range(1, 24)) begin
				b = 8'($urandom_range(0, 255));
				push_byte((b == CH_LF) ? 8'h0b : b);
			end
			push_byte(CH_LF);
			return;
		end else if (roll < 84) begin
			// around the line length limit
			repeat ($urandom_range(MAX_LINE_BYTES - 2, MAX_LINE_BYTES + 6))
				push_byte(8'($urandom_range(8'h21, 8'h7e)));
			push_byte(CH_LF);
			return;
		end else if (roll < 87) begin
			push_byte(CH_LF);
			return;
		end else if (roll < 90) begin
			skip_tick = 1;
		end else if (roll < 93) begin
			cr_twice = 1;
		end else if (roll < 96) begin
			push_str($sformatf("%0d", tick_v));
			push_byte(CH_LF);
			return;
		end else begin
			n_hex = 0;
		end
		if (!skip_tick) begin
			if (zero_lead) push_byte(CH_ZERO);
			push_str($sformatf("%0d", tick_v));
		end
		repeat (n_sp) push_byte(CH_SPACE);
		for (int i = 0; i < n_hex; i++) begin
			d = $urandom_range(0, 15);
			if (i == cr_at) push_byte(CH_CR);
			if (i == upper_at) push_byte(8'(8'h41 + d % 6));
			else push_byte(hex_char(d));
		end
		if (cr_twice) push_byte(CH_CR);
		if (cr_end) push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic gen_stream(input int max_n);
		int n;
		n = $urandom_range(0, max_n);
		for (int i = 0; i < n; i++) gen_line(i);
		case ($urandom_range(0, 5))
			0: begin
				// unterminated line closed by end of stream
				push_str($sformatf("%0d", n));
				push_byte(CH_SPACE);
				repeat ($urandom_range(0, HEX_DIGITS))
					push_byte(hex_char($urandom_range(0, 15)));
			end
			1: push_byte(CH_CR);
			default: ;
		endcase
		push_eos();
	endtask

	task automatic wait_results_drained();
		while (!(bytes_to_send.size() == 0 && !in_valid && pending_results.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_line_limit(input logic [CNT_W-1:0] v);
		wait_results_drained();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_reg = v;
		limit_settings++;
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] lim_v, input int budget,
			input bit pause_mid);
		int start, cap;
		bit paused;
		set_line_limit(lim_v);
		cap = line_cap(lim_v) + 1;
		if (cap > 7) cap = 7;
		start = words_queued;
		paused = 0;
		while (words_queued - start < budget) begin
			gen_stream(cap);
			if (pause_mid && !paused && words_queued - start >= budget / 2) begin
				wait_results_drained();
				paused = 1;
			end
		end
	endtask

	initial begin
		clear_stream_st();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stream, all-ones hash with stripped cr, then a lone cr left pending
		push_eos();
		push_str("0 ffffffffffffffff");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_CR);
		push_eos();

		// budgets leave room for the last stream of each phase running past them
		run_phase(CNT_W'(1), 80, 0);
		run_phase(CNT_W'(0), 45, 0);
		run_phase(CNT_W'(2), 95, 0);
		run_phase({CNT_W{1'b1}}, 230, 1);
		run_phase(CNT_W'(3), 90, 0);
		run_phase(CNT_W'($urandom_range(4, 9)), 110, 0);
		run_phase(CNT_W'(LINE_LIMIT_CAP), 140, 0);

		wait_results_drained();
		repeat (16) @(posedge clk);
		$display("%0d words over %0d line limits, %0d line results checked", words_sent,
			limit_settings, line_results);
		$display("verdicts: ok %0d malformed %0d break %0d unbounded %0d empty %0d",
			verdicts[ST_OK], verdicts[ST_MALFORMED], verdicts[ST_SEQ_BREAK],
			verdicts[ST_UNBOUNDED], verdicts[ST_NO_LINES]);
		if (mismatches == 0) begin
			$display("tb_tick_hash_line_validator: clean");
		end else begin
			$display("tb_tick_hash_line_validator: errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/tkhv_pkg.sv
hw/rtl/tkhv_parser.sv
hw/rtl/tkhv_result_fifo.sv
hw/rtl/tick_hash_line_validator.sv
verif/tb_tick_hash_line_validator.sv
